>>> hw/rtl/atms_pkg.sv
// Shared types and constants of the ADC trimmed-mean scaler.
`default_nettype none

package atms_pkg;

    // Window of samples that makes up one result.
    localparam int unsigned WINDOW_SIZE = 10;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned MEAN_SHIFT  = 3;

    // Field widths of the configuration registers.
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned FLOOR_W = 12;
    localparam int unsigned GAIN_W  = 24;
    localparam int unsigned VALUE_W = 32;

    // Configuration port widths.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Scaling modes.
    localparam logic [MODE_W-1:0] MODE_LOOP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH       = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [MODE_W-1:0]  RST_MODE   = MODE_LINEAR;
    localparam logic [FLOOR_W-1:0] RST_FLOOR  = 12'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN   = 24'h01_0000;
    localparam logic [VALUE_W-1:0] RST_OFFSET = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] RST_LOW    = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] RST_HIGH   = 32'h7FFF_FFFF;

    // Configuration seen by the datapath. Values are Q16.16 two's complement.
    typedef struct packed {
        logic [MODE_W-1:0]  scale_mode;
        logic [FLOOR_W-1:0] floor_code;
        logic [GAIN_W-1:0]  gain;
        logic [VALUE_W-1:0] offset_value;
        logic [VALUE_W-1:0] low_value;
        logic [VALUE_W-1:0] high_value;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/atms_cfg_regs.sv
// Configuration register file of the ADC trimmed-mean scaler.
`default_nettype none

module atms_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [atms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [atms_pkg::CFG_DATA_W-1:0]   cfg_data,
    output      atms_pkg::cfg_t                    cfg
);

    atms_pkg::cfg_t cfg_reg;
    atms_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [atms_pkg::MODE_W-1:0] mode_wr;

    // Writes are always taken; the port is always ready.
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign mode_wr   = cfg_data[atms_pkg::MODE_W-1:0];

    // Decode the register index; an unknown mode code leaves the mode unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_index)
                atms_pkg::REG_SCALE_MODE:
                begin
                    if (mode_wr inside {atms_pkg::MODE_LOOP, atms_pkg::MODE_LINEAR,
                                        atms_pkg::MODE_DOUBLE})
                    begin
                        cfg_next.scale_mode = mode_wr;
                    end
                end
                atms_pkg::REG_FLOOR_CODE:
                    cfg_next.floor_code = cfg_data[atms_pkg::FLOOR_W-1:0];
                atms_pkg::REG_GAIN:
                    cfg_next.gain = cfg_data[atms_pkg::GAIN_W-1:0];
                atms_pkg::REG_OFFSET:
                    cfg_next.offset_value = cfg_data[atms_pkg::VALUE_W-1:0];
                atms_pkg::REG_LOW:
                    cfg_next.low_value = cfg_data[atms_pkg::VALUE_W-1:0];
                atms_pkg::REG_HIGH:
                    cfg_next.high_value = cfg_data[atms_pkg::VALUE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_mode   <= atms_pkg::RST_MODE;
            cfg_reg.floor_code   <= atms_pkg::RST_FLOOR;
            cfg_reg.gain         <= atms_pkg::RST_GAIN;
            cfg_reg.offset_value <= atms_pkg::RST_OFFSET;
            cfg_reg.low_value    <= atms_pkg::RST_LOW;
            cfg_reg.high_value   <= atms_pkg::RST_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

`ifndef ASSERT_OFF
    // The mode register never holds the unused code.
    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_reg.scale_mode == atms_pkg::MODE_LOOP
        || cfg_reg.scale_mode == atms_pkg::MODE_LINEAR
        || cfg_reg.scale_mode == atms_pkg::MODE_DOUBLE)
        else $error("scale mode register holds an illegal code");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/atms_window_acc.sv
// Window accumulator: running sum, maximum, minimum and trimmed mean.
`default_nettype none

module atms_window_acc #(
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output      logic                   win_valid,
    input  wire logic                   win_ready,
    output      logic [SAMPLE_BITS-1:0] win_mean
);

    localparam int unsigned SUM_W = SAMPLE_BITS + 4;

    logic [atms_pkg::CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0]     max_reg, max_next;
    logic [SAMPLE_BITS-1:0]     min_reg, min_next;
    logic                       win_valid_reg, win_valid_next;
    logic [SAMPLE_BITS-1:0]     win_mean_reg, win_mean_next;

    logic                   accept;
    logic                   last;
    logic                   adv;
    logic [SUM_W-1:0]       sum_upd;
    logic [SAMPLE_BITS-1:0] max_upd;
    logic [SAMPLE_BITS-1:0] min_upd;
    logic [SUM_W-1:0]       trimmed;

    // The window register may be refilled when empty or when it is being taken.
    assign adv      = !win_valid_reg || win_ready;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;
    assign last     = count_reg == atms_pkg::CNT_W'(atms_pkg::WINDOW_SIZE - 1);

    // Running statistics including the current sample.
    assign sum_upd = sum_reg + SUM_W'(sample);
    assign max_upd = (sample > max_reg) ? sample : max_reg;
    assign min_upd = (sample < min_reg) ? sample : min_reg;
    assign trimmed = sum_upd - SUM_W'(max_upd) - SUM_W'(min_upd);

    // Update the window state and hand off the mean on the last sample.
    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        win_valid_next = win_valid_reg;
        win_mean_next  = win_mean_reg;
        if (adv)
        begin
            win_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (last)
            begin
                count_next     = '0;
                sum_next       = '0;
                max_next       = '0;
                min_next       = '1;
                win_valid_next = 1'b1;
                win_mean_next  = trimmed[atms_pkg::MEAN_SHIFT +: SAMPLE_BITS];
            end
            else
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_upd;
                max_next   = max_upd;
                min_next   = min_upd;
            end
        end
    end

    // Control and statistics registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            max_reg       <= '0;
            min_reg       <= '1;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            win_valid_reg <= win_valid_next;
        end
    end

    // Mean payload register.
    always_ff @(posedge clk)
    begin
        win_mean_reg <= win_mean_next;
    end

    assign win_valid = win_valid_reg;
    assign win_mean  = win_mean_reg;

`ifndef ASSERT_OFF
    // The sample counter stays inside the window.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= atms_pkg::CNT_W'(atms_pkg::WINDOW_SIZE - 1))
        else $error("sample counter beyond window");

    // Closing a window clears the statistics and presents a mean.
    a_window_close: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> win_valid_reg && count_reg == '0 && sum_reg == '0)
        else $error("window did not close cleanly");

    // A mean that is not taken stays unchanged.
    a_mean_hold: assert property (@(posedge clk) disable iff (!rst_n)
        win_valid_reg && !win_ready |=> win_valid_reg && $stable(win_mean_reg))
        else $error("pending mean was lost or changed");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/atms_scaler.sv
// Scaling datapath: floor, gain product, offset or base value, upper clamp and result register.
`default_nettype none

module atms_scaler #(
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire atms_pkg::cfg_t                  cfg,
    input  wire logic                            win_valid,
    output      logic                            win_ready,
    input  wire logic [SAMPLE_BITS-1:0]          win_mean,
    output      logic                            out_valid,
    input  wire logic                            out_stall,
    output      logic [SAMPLE_BITS-1:0]          mean_code,
    output      logic signed [atms_pkg::VALUE_W-1:0] scaled_value,
    output      logic                            clamped
);

    localparam int unsigned X_W  = (SAMPLE_BITS > atms_pkg::FLOOR_W) ?
                                   SAMPLE_BITS : atms_pkg::FLOOR_W;
    localparam int unsigned MUL_W = atms_pkg::GAIN_W + X_W;
    localparam int unsigned PRD_W = MUL_W + 1;
    localparam int unsigned V_W   = PRD_W + 2;

    logic                   prd_valid_reg;
    logic [PRD_W-1:0]       prd_reg;
    logic [SAMPLE_BITS-1:0] prd_mean_reg;

    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        mean_code_reg;
    logic [atms_pkg::VALUE_W-1:0]  scaled_reg;
    logic                          clamped_reg;

    logic              adv_out;
    logic              adv_prd;
    logic [X_W-1:0]    mean_ext;
    logic [X_W-1:0]    floor_ext;
    logic [X_W-1:0]    x_sel;
    logic [MUL_W-1:0]  mul;
    logic [PRD_W-1:0]  prd_next;
    logic signed [V_W-1:0] prd_s;
    logic signed [V_W-1:0] offset_s;
    logic signed [V_W-1:0] low_s;
    logic signed [V_W-1:0] high_s;
    logic signed [V_W-1:0] v;
    logic                  over;

    // Each stage moves when its successor has room.
    assign adv_out   = !out_valid_reg || !out_stall;
    assign adv_prd   = !prd_valid_reg || adv_out;
    assign win_ready = adv_prd;

    // Current-loop mode raises the mean to the 4 mA code before the product.
    assign mean_ext  = X_W'(win_mean);
    assign floor_ext = X_W'(cfg.floor_code);
    assign x_sel     = (cfg.scale_mode == atms_pkg::MODE_LOOP && mean_ext < floor_ext) ?
                       floor_ext : mean_ext;
    assign mul       = MUL_W'(cfg.gain) * MUL_W'(x_sel);
    assign prd_next  = (cfg.scale_mode == atms_pkg::MODE_DOUBLE) ?
                       {mul, 1'b0} : {1'b0, mul};

    // Product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prd_valid_reg <= 1'b0;
        end
        else if (adv_prd)
        begin
            prd_valid_reg <= win_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_prd && win_valid)
        begin
            prd_reg      <= prd_next;
            prd_mean_reg <= win_mean;
        end
    end

    // Offset or base value, then the upper clamp.
    assign prd_s    = $signed({2'b00, prd_reg});
    assign offset_s = $signed({{(V_W - atms_pkg::VALUE_W){cfg.offset_value[atms_pkg::VALUE_W-1]}},
                               cfg.offset_value});
    assign low_s    = $signed({{(V_W - atms_pkg::VALUE_W){cfg.low_value[atms_pkg::VALUE_W-1]}},
                               cfg.low_value});
    assign high_s   = $signed({{(V_W - atms_pkg::VALUE_W){cfg.high_value[atms_pkg::VALUE_W-1]}},
                               cfg.high_value});
    assign v        = (cfg.scale_mode == atms_pkg::MODE_LOOP) ? (prd_s - offset_s)
                                                              : (prd_s + low_s);
    assign over     = v > high_s;

    // Result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= prd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && prd_valid_reg)
        begin
            mean_code_reg <= prd_mean_reg;
            scaled_reg    <= over ? cfg.high_value : v[atms_pkg::VALUE_W-1:0];
            clamped_reg   <= over;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mean_code    = mean_code_reg;
    assign scaled_value = $signed(scaled_reg);
    assign clamped      = clamped_reg;

`ifndef ASSERT_OFF
    // A product waiting on a full result register keeps its value.
    a_prd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        prd_valid_reg && !adv_out |=> prd_valid_reg && $stable(prd_reg))
        else $error("pending product was lost or changed");

    // A product leaving its stage always lands in the result register.
    a_prd_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        prd_valid_reg && adv_out |=> out_valid_reg)
        else $error("product did not reach the result register");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/adc_trimmed_mean_scaler.sv
// Top level of the ADC trimmed-mean scaler.
`default_nettype none

// Takes one ADC sample per clock cycle while in_stall is low and, after every
// tenth sample, emits one result transaction: the mean of the window with one
// highest and one lowest sample removed, and that mean scaled to a signed
// Q16.16 engineering value (4-20 mA loop, linear, or linear doubled) with an
// upper clamp flag. The running sum, maximum and minimum update as each sample
// is taken, so the block takes one input transaction every cycle unless the
// output side stalls it; the result passes from the mean register through the
// gain product register into the output register. Configuration is written
// through a separate index/data port that is always ready; registers should
// only be changed while no result is pending.
module adc_trimmed_mean_scaler #(
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output      logic                                 in_stall,
    input  wire logic [SAMPLE_BITS-1:0]               sample,
    output      logic                                 out_valid,
    input  wire logic                                 out_stall,
    output      logic [SAMPLE_BITS-1:0]               mean_code,
    output      logic signed [atms_pkg::VALUE_W-1:0]  scaled_value,
    output      logic                                 clamped,
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [atms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [atms_pkg::CFG_DATA_W-1:0]      cfg_data
);

    atms_pkg::cfg_t         cfg;
    logic                   win_valid;
    logic                   win_ready;
    logic [SAMPLE_BITS-1:0] win_mean;

    // Configuration registers.
    atms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Window statistics and trimmed mean.
    atms_window_acc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win_mean  (win_mean)
    );

    // Scaling and result register.
    atms_scaler #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .win_valid    (win_valid),
        .win_ready    (win_ready),
        .win_mean     (win_mean),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean_code    (mean_code),
        .scaled_value (scaled_value),
        .clamped      (clamped)
    );

endmodule

`default_nettype wire

>>> verif/tb_adc_trimmed_mean_scaler.sv
// Self-checking testbench for the ADC trimmed-mean scaler.
module tb_adc_trimmed_mean_scaler;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = 12;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT = 10;

    // Codes that the block must ignore on the register port.
    localparam logic [atms_pkg::MODE_W-1:0] MODE_INVALID = 2'd3;
    localparam logic [atms_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [atms_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

    // Shapes of sample windows used by the random stimulus.
    typedef enum int {WIN_UNIFORM, WIN_FLAT, WIN_NARROW, WIN_RAILS} window_style_t;

    // One result transaction: trimmed mean and its scaled value.
    typedef struct {
        logic [SAMPLE_W-1:0]                 mean;
        logic signed [atms_pkg::VALUE_W-1:0] value;
        logic                                clamped;
    } scaled_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [SAMPLE_W-1:0] sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [SAMPLE_W-1:0] mean_code;
    logic signed [atms_pkg::VALUE_W-1:0] scaled_value;
    logic clamped;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [atms_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [atms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow configuration and window state of the predictor.
    logic [atms_pkg::MODE_W-1:0] shadow_mode = atms_pkg::RST_MODE;
    logic [atms_pkg::FLOOR_W-1:0] shadow_floor = atms_pkg::RST_FLOOR;
    logic [atms_pkg::GAIN_W-1:0] shadow_gain = atms_pkg::RST_GAIN;
    logic signed [atms_pkg::VALUE_W-1:0] shadow_offset = atms_pkg::RST_OFFSET;
    logic signed [atms_pkg::VALUE_W-1:0] shadow_low = atms_pkg::RST_LOW;
    logic signed [atms_pkg::VALUE_W-1:0] shadow_high = atms_pkg::RST_HIGH;
    int win_count = 0;
    logic [15:0] win_sum = '0;
    logic [SAMPLE_W-1:0] win_max = '0;
    logic [SAMPLE_W-1:0] win_min = '1;

    scaled_result_t awaited_results[$];
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    adc_trimmed_mean_scaler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean_code    (mean_code),
        .scaled_value (scaled_value),
        .clamped      (clamped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // Mirror a register write into the shadow configuration.
    function automatic void shadow_write(logic [atms_pkg::CFG_IDX_W-1:0] idx,
                                         logic [atms_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            atms_pkg::REG_SCALE_MODE:
            begin
                if (data[atms_pkg::MODE_W-1:0] != MODE_INVALID)
                    shadow_mode = data[atms_pkg::MODE_W-1:0];
            end
            atms_pkg::REG_FLOOR_CODE: shadow_floor = data[atms_pkg::FLOOR_W-1:0];
            atms_pkg::REG_GAIN:       shadow_gain = data[atms_pkg::GAIN_W-1:0];
            atms_pkg::REG_OFFSET:     shadow_offset = signed'(data[atms_pkg::VALUE_W-1:0]);
            atms_pkg::REG_LOW:        shadow_low = signed'(data[atms_pkg::VALUE_W-1:0]);
            atms_pkg::REG_HIGH:       shadow_high = signed'(data[atms_pkg::VALUE_W-1:0]);
            default:                  ;
        endcase
    endfunction

    // Accumulate one sample; on the last sample of a window queue the scaled mean.
    function automatic void predict_trimmed_mean(logic [SAMPLE_W-1:0] s);
        logic [15:0] trimmed;
        logic [SAMPLE_W-1:0] x;
        longint scaled;
        scaled_result_t res;
        win_sum = win_sum + 16'(s);
        if (s > win_max)
            win_max = s;
        if (s < win_min)
            win_min = s;
        win_count++;
        if (win_count < atms_pkg::WINDOW_SIZE)
            return;
        trimmed = win_sum - 16'(win_max) - 16'(win_min);
        res.mean = SAMPLE_W'(trimmed >> atms_pkg::MEAN_SHIFT);
        win_count = 0;
        win_sum = '0;
        win_max = '0;
        win_min = '1;
        x = res.mean;
        if (shadow_mode == atms_pkg::MODE_LOOP)
        begin
            if (x < shadow_floor)
                x = shadow_floor;
            scaled = longint'(shadow_gain) * longint'(x) - longint'(shadow_offset);
        end
        else if (shadow_mode == atms_pkg::MODE_LINEAR)
            scaled = longint'(shadow_gain) * longint'(x) + longint'(shadow_low);
        else
            scaled = 2 * longint'(shadow_gain) * longint'(x) + longint'(shadow_low);
        res.clamped = 1'b0;
        if (scaled > longint'(shadow_high))
        begin
            scaled = longint'(shadow_high);
            res.clamped = 1'b1;
        end
        res.value = scaled[atms_pkg::VALUE_W-1:0];
        awaited_results.push_back(res);
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    // Offer one sample, idling at random first, and hold it until it is taken.
    task automatic send_sample(logic [SAMPLE_W-1:0] s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (in_stall);
        predict_trimmed_mean(s);
    endtask

    // Stop offering samples and let every awaited result come out.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [atms_pkg::CFG_IDX_W-1:0] idx,
                             logic [atms_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_write(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Program one of the register settings, always from an idle block.
    task automatic apply_setting(int which);
        wait_drained();
        case (which)
            0:
            begin
                cfg_write(atms_pkg::REG_SCALE_MODE, 32'(atms_pkg::MODE_LINEAR));
                cfg_write(atms_pkg::REG_GAIN, 32'(atms_pkg::RST_GAIN));
                cfg_write(atms_pkg::REG_LOW, atms_pkg::RST_LOW);
                cfg_write(atms_pkg::REG_HIGH, atms_pkg::RST_HIGH);
            end
            1:
            begin
                cfg_write(atms_pkg::REG_SCALE_MODE, 32'(atms_pkg::MODE_LOOP));
                cfg_write(atms_pkg::REG_FLOOR_CODE, $urandom);
                cfg_write(atms_pkg::REG_GAIN, $urandom);
                cfg_write(atms_pkg::REG_OFFSET, $urandom);
                cfg_write(atms_pkg::REG_HIGH, 32'h7FFF_FFFF);
                // An out-of-range mode must leave the loop mode in place.
                cfg_write(atms_pkg::REG_SCALE_MODE,
                          {30'($urandom_range(32'h3FFF_FFFF)), MODE_INVALID});
            end
            2:
            begin
                cfg_write(atms_pkg::REG_SCALE_MODE, 32'(atms_pkg::MODE_DOUBLE));
                cfg_write(atms_pkg::REG_GAIN, 32'hFFFF_FFFF);
                cfg_write(atms_pkg::REG_LOW, 32'h8000_0000);
                cfg_write(atms_pkg::REG_HIGH, 32'h7FFF_FFFF);
                cfg_write(REG_UNUSED_A, $urandom);
                cfg_write(REG_UNUSED_B, $urandom);
            end
            3:
            begin
                // Zero gain with the low value above the clamp: every result clamps.
                cfg_write(atms_pkg::REG_SCALE_MODE, 32'(atms_pkg::MODE_LINEAR));
                cfg_write(atms_pkg::REG_GAIN, 32'h0000_0000);
                cfg_write(atms_pkg::REG_LOW, 32'h7FFF_FFFF);
                cfg_write(atms_pkg::REG_HIGH, 32'h8000_0000);
            end
            4:
            begin
                cfg_write(atms_pkg::REG_SCALE_MODE, 32'(atms_pkg::MODE_LOOP));
                cfg_write(atms_pkg::REG_FLOOR_CODE, 32'hFFFF_FFFF);
                cfg_write(atms_pkg::REG_GAIN, 32'h00FF_FFFF);
                cfg_write(atms_pkg::REG_OFFSET, 32'h8000_0000);
                cfg_write(atms_pkg::REG_HIGH, $urandom);
            end
            default:
            begin
                cfg_write(atms_pkg::REG_SCALE_MODE, $urandom);
                cfg_write(atms_pkg::REG_FLOOR_CODE, $urandom);
                cfg_write(atms_pkg::REG_GAIN, $urandom);
                cfg_write(atms_pkg::REG_OFFSET, $urandom);
                cfg_write(atms_pkg::REG_LOW, $urandom);
                cfg_write(atms_pkg::REG_HIGH, $urandom);
                cfg_write(atms_pkg::CFG_IDX_W'($urandom_range(7)), $urandom);
            end
        endcase
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(window_style_t style,
                                                        logic [SAMPLE_W-1:0] base);
        int v;
        case (style)
            WIN_FLAT:   v = base;
            WIN_NARROW: v = int'(base) + $urandom_range(15);
            WIN_RAILS:  v = $urandom_range(1) ? SAMPLE_MAX : 0;
            default:    v = $urandom_range(SAMPLE_MAX);
        endcase
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    // Send whole windows of random samples in a random shape each.
    task automatic run_windows(int count);
        window_style_t style;
        logic [SAMPLE_W-1:0] base;
        for (int w = 0; w < count; w++)
        begin
            style = window_style_t'($urandom_range(3));
            base = SAMPLE_W'($urandom_range(SAMPLE_MAX));
            for (int i = 0; i < atms_pkg::WINDOW_SIZE; i++)
                send_sample(pick_sample(style, base));
        end
    endtask

    // Windows at the sample extremes, including equal extremes, at reset settings.
    task automatic test_directed_windows();
        for (int i = 0; i < atms_pkg::WINDOW_SIZE; i++)
            send_sample('0);
        for (int i = 0; i < atms_pkg::WINDOW_SIZE; i++)
            send_sample(SAMPLE_W'(SAMPLE_MAX));
        for (int i = 0; i < atms_pkg::WINDOW_SIZE; i++)
            send_sample((i % 2 == 0) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(i * 300));
    endtask

    // Every register setting under one mix of sender and receiver idling.
    task automatic test_idle_stage(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < 6; k++)
        begin
            apply_setting(k);
            run_windows(4);
        end
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = HOLD_OFF_CYCLES;
        run_windows(4);
    endtask

    // The sender pauses until every result has come, then resumes.
    task automatic test_drain_pause();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        run_windows(2);
        wait_drained();
        run_windows(2);
    endtask

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each result transaction with the oldest awaited one.
    always @(posedge clk)
    begin
        scaled_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                note_failure($sformatf("unexpected result: mean %0d value %0d clamped %0b",
                                       mean_code, scaled_value, clamped));
            else
            begin
                exp_res = awaited_results.pop_front();
                if (mean_code !== exp_res.mean || scaled_value !== exp_res.value
                    || clamped !== exp_res.clamped)
                    note_failure($sformatf(
                        "mismatch: expected mean %0d value %0d clamped %0b, got %0d %0d %0b",
                        exp_res.mean, exp_res.value, exp_res.clamped,
                        mean_code, scaled_value, clamped));
            end
        end
    end

    // Watchdog on cycles in which no transaction moves on any port.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_windows();
        test_idle_stage(22, 63);
        test_idle_stage(63, 22);
        test_idle_stage(0, 0);
        test_output_backpressure();
        test_drain_pause();
        wait_drained();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
